// ===== design/bal_pkg.sv =====
package bal_pkg;

  // field widths of the channels
  localparam int CMD_W    = 3;
  localparam int VAL_W    = 32;
  localparam int POS_W    = 5;
  localparam int STATUS_W = 2;
  localparam int IDX_W    = 4;
  localparam int CNT_W    = 5;

  localparam int DEPTH_DEFAULT = 16;

  // command codes
  localparam logic [CMD_W-1:0] CMD_INSERT = 3'd0;
  localparam logic [CMD_W-1:0] CMD_DELETE = 3'd1;
  localparam logic [CMD_W-1:0] CMD_LOCATE = 3'd2;
  localparam logic [CMD_W-1:0] CMD_SORTED = 3'd3;
  localparam logic [CMD_W-1:0] CMD_READ   = 3'd4;

  // status codes
  localparam logic [STATUS_W-1:0] ST_OK       = 2'd0;
  localparam logic [STATUS_W-1:0] ST_FULL     = 2'd1;
  localparam logic [STATUS_W-1:0] ST_BADPOS   = 2'd2;
  localparam logic [STATUS_W-1:0] ST_NOTFOUND = 2'd3;

  // index register operations
  localparam logic [2:0] IDX_HOLD  = 3'd0;
  localparam logic [2:0] IDX_ZERO  = 3'd1;
  localparam logic [2:0] IDX_COUNT = 3'd2;
  localparam logic [2:0] IDX_POS   = 3'd3;
  localparam logic [2:0] IDX_INC   = 3'd4;
  localparam logic [2:0] IDX_DEC   = 3'd5;

  // memory read address select
  localparam logic [1:0] RD_IDX    = 2'd0;
  localparam logic [1:0] RD_IDX_M1 = 2'd1;
  localparam logic [1:0] RD_IDX_P1 = 2'd2;
  localparam logic [1:0] RD_POS    = 2'd3;

  // memory write data select
  localparam logic WR_RDATA = 1'b0;
  localparam logic WR_VALUE = 1'b1;

  // count operations
  localparam logic [1:0] CNT_HOLD = 2'd0;
  localparam logic [1:0] CNT_INC  = 2'd1;
  localparam logic [1:0] CNT_DEC  = 2'd2;

  // result index and read data select
  localparam logic [1:0] RES_IDX_ZERO = 2'd0;
  localparam logic [1:0] RES_IDX_IDX  = 2'd1;
  localparam logic [1:0] RES_IDX_POS  = 2'd2;
  localparam logic RES_RD_ZERO = 1'b0;
  localparam logic RES_RD_DATA = 1'b1;

  // controller to datapath
  typedef struct packed {
    logic                latch;
    logic [2:0]          idx_op;
    logic                pos_from_idx;
    logic                rd_en;
    logic [1:0]          rd_sel;
    logic                wr_en;
    logic                wr_sel;
    logic [1:0]          cnt_op;
    logic                res_load;
    logic [STATUS_W-1:0] res_status;
    logic [1:0]          res_idx_sel;
    logic                res_rd_sel;
    logic                out_load;
  } bal_ctl_t;

  // datapath to controller
  typedef struct packed {
    logic [CMD_W-1:0] cmd;
    logic             full;
    logic             pos_gt_cnt;
    logic             pos_ge_cnt;
    logic             idx_eq_pos;
    logic             idx_lt_cnt;
    logic             idx_p1_lt_cnt;
    logic             match;
    logic             less;
    logic             out_free;
  } bal_flags_t;

endpackage

// ===== design/bal_req_if.sv =====
interface bal_req_if;
  import bal_pkg::*;

  logic                    valid;
  logic                    ready;
  logic [CMD_W-1:0]        command;
  logic signed [VAL_W-1:0] value;
  logic [POS_W-1:0]        position;

  modport source(output valid, command, value, position, input ready);
  modport sink(input valid, command, value, position, output ready);
endinterface

// ===== design/bal_rsp_if.sv =====
interface bal_rsp_if;
  import bal_pkg::*;

  logic                    valid;
  logic                    ready;
  logic [STATUS_W-1:0]     status;
  logic [IDX_W-1:0]        found_index;
  logic signed [VAL_W-1:0] read_value;
  logic [CNT_W-1:0]        entry_count;

  modport source(output valid, status, found_index, read_value, entry_count, input ready);
  modport sink(input valid, status, found_index, read_value, entry_count, output ready);
endinterface

// ===== design/bal_datapath.sv =====
module bal_datapath #(
  parameter int DEPTH = bal_pkg::DEPTH_DEFAULT
) (
  input  logic                             clk,
  input  logic                             rst,
  input  bal_pkg::bal_ctl_t                ctl,
  input  logic [bal_pkg::CMD_W-1:0]        command,
  input  logic signed [bal_pkg::VAL_W-1:0] value,
  input  logic [bal_pkg::POS_W-1:0]        position,
  output bal_pkg::bal_flags_t              flags,
  output logic                             out_valid,
  input  logic                             out_ready,
  output logic [bal_pkg::STATUS_W-1:0]     status,
  output logic [bal_pkg::IDX_W-1:0]        found_index,
  output logic signed [bal_pkg::VAL_W-1:0] read_value,
  output logic [bal_pkg::CNT_W-1:0]        entry_count
);
  import bal_pkg::*;

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);
  localparam int IW = (CW > POS_W) ? CW : POS_W;

  logic signed [VAL_W-1:0] mem [DEPTH];
  logic signed [VAL_W-1:0] rdata;

  logic [CMD_W-1:0]        cmd_r;
  logic signed [VAL_W-1:0] val_r;
  logic [IW-1:0]           pos_r;
  logic [IW-1:0]           idx;
  logic [CW-1:0]           count;

  logic [STATUS_W-1:0]     res_status;
  logic [IW-1:0]           res_idx;
  logic signed [VAL_W-1:0] res_rd;

  logic [IW-1:0]           cnt_ext;
  logic [IW:0]             idx_p1;
  logic [IW-1:0]           raddr;
  logic signed [VAL_W-1:0] wdata;

  assign cnt_ext = IW'(count);
  assign idx_p1  = {1'b0, idx} + (IW+1)'(1);

  always_comb begin
    case (ctl.rd_sel)
      RD_IDX_M1: raddr = idx - IW'(1);
      RD_IDX_P1: raddr = idx_p1[IW-1:0];
      RD_POS:    raddr = pos_r;
      default:   raddr = idx;
    endcase
  end

  assign wdata = (ctl.wr_sel == WR_VALUE) ? val_r : rdata;

  // list storage, one read and one write a cycle
  always_ff @(posedge clk) begin
    if (ctl.wr_en) begin
      mem[idx[AW-1:0]] <= wdata;
    end
    if (ctl.rd_en) begin
      rdata <= mem[raddr[AW-1:0]];
    end
  end

  // latched command
  always_ff @(posedge clk) begin
    if (ctl.latch) begin
      cmd_r <= command;
      val_r <= value;
      pos_r <= IW'(position);
    end else if (ctl.pos_from_idx) begin
      pos_r <= idx;
    end
  end

  always_ff @(posedge clk) begin
    case (ctl.idx_op)
      IDX_ZERO:  idx <= '0;
      IDX_COUNT: idx <= cnt_ext;
      IDX_POS:   idx <= pos_r;
      IDX_INC:   idx <= idx_p1[IW-1:0];
      IDX_DEC:   idx <= idx - IW'(1);
      default:   idx <= idx;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else begin
      case (ctl.cnt_op)
        CNT_INC: count <= count + CW'(1);
        CNT_DEC: count <= count - CW'(1);
        default: count <= count;
      endcase
    end
  end

  // pending result
  always_ff @(posedge clk) begin
    if (ctl.res_load) begin
      res_status <= ctl.res_status;
      case (ctl.res_idx_sel)
        RES_IDX_IDX: res_idx <= idx;
        RES_IDX_POS: res_idx <= pos_r;
        default:     res_idx <= '0;
      endcase
      res_rd <= (ctl.res_rd_sel == RES_RD_DATA) ? rdata : '0;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (ctl.out_load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.out_load) begin
      status      <= res_status;
      found_index <= res_idx[IDX_W-1:0];
      read_value  <= res_rd;
      entry_count <= cnt_ext[CNT_W-1:0];
    end
  end

  always_comb begin
    flags.cmd           = cmd_r;
    flags.full          = (cnt_ext == IW'(DEPTH));
    flags.pos_gt_cnt    = (pos_r > cnt_ext);
    flags.pos_ge_cnt    = (pos_r >= cnt_ext);
    flags.idx_eq_pos    = (idx == pos_r);
    flags.idx_lt_cnt    = (idx < cnt_ext);
    flags.idx_p1_lt_cnt = (idx_p1 < {1'b0, cnt_ext});
    flags.match         = (rdata == val_r);
    flags.less          = (rdata < val_r);
    flags.out_free      = !out_valid || out_ready;
  end

endmodule

// ===== design/bal_controller.sv =====
module bal_controller (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_ready,
  input  bal_pkg::bal_flags_t flags,
  output bal_pkg::bal_ctl_t   ctl
);
  import bal_pkg::*;

  localparam logic [3:0] S_IDLE     = 4'd0;
  localparam logic [3:0] S_DECODE   = 4'd1;
  localparam logic [3:0] S_UP_CHK   = 4'd2;
  localparam logic [3:0] S_UP_WR    = 4'd3;
  localparam logic [3:0] S_DN_CHK   = 4'd4;
  localparam logic [3:0] S_DN_WR    = 4'd5;
  localparam logic [3:0] S_SCAN_CHK = 4'd6;
  localparam logic [3:0] S_SCAN_CMP = 4'd7;
  localparam logic [3:0] S_RD_WAIT  = 4'd8;
  localparam logic [3:0] S_FIN      = 4'd9;

  logic [3:0] state;
  logic [3:0] state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  assign in_ready = (state == S_IDLE);

  always_comb begin
    state_next = state;
    ctl        = '0;
    unique case (state)
      S_IDLE: begin
        if (in_valid) begin
          ctl.latch  = 1'b1;
          state_next = S_DECODE;
        end
      end
      S_DECODE: begin
        unique case (flags.cmd)
          CMD_INSERT: begin
            if (flags.full) begin
              ctl.res_load   = 1'b1;
              ctl.res_status = ST_FULL;
              state_next     = S_FIN;
            end else if (flags.pos_gt_cnt) begin
              ctl.res_load   = 1'b1;
              ctl.res_status = ST_BADPOS;
              state_next     = S_FIN;
            end else begin
              ctl.idx_op = IDX_COUNT;
              state_next = S_UP_CHK;
            end
          end
          CMD_DELETE: begin
            if (flags.pos_ge_cnt) begin
              ctl.res_load   = 1'b1;
              ctl.res_status = ST_BADPOS;
              state_next     = S_FIN;
            end else begin
              ctl.idx_op = IDX_POS;
              state_next = S_DN_CHK;
            end
          end
          CMD_LOCATE: begin
            ctl.idx_op = IDX_ZERO;
            state_next = S_SCAN_CHK;
          end
          CMD_SORTED: begin
            if (flags.full) begin
              ctl.res_load   = 1'b1;
              ctl.res_status = ST_FULL;
              state_next     = S_FIN;
            end else begin
              ctl.idx_op = IDX_ZERO;
              state_next = S_SCAN_CHK;
            end
          end
          CMD_READ: begin
            if (flags.pos_ge_cnt) begin
              ctl.res_load   = 1'b1;
              ctl.res_status = ST_BADPOS;
              state_next     = S_FIN;
            end else begin
              ctl.rd_en  = 1'b1;
              ctl.rd_sel = RD_POS;
              state_next = S_RD_WAIT;
            end
          end
          default: begin
            ctl.res_load   = 1'b1;
            ctl.res_status = ST_OK;
            state_next     = S_FIN;
          end
        endcase
      end
      S_UP_CHK: begin
        if (flags.idx_eq_pos) begin
          ctl.wr_en       = 1'b1;
          ctl.wr_sel      = WR_VALUE;
          ctl.cnt_op      = CNT_INC;
          ctl.res_load    = 1'b1;
          ctl.res_status  = ST_OK;
          ctl.res_idx_sel = RES_IDX_POS;
          state_next      = S_FIN;
        end else begin
          ctl.rd_en  = 1'b1;
          ctl.rd_sel = RD_IDX_M1;
          state_next = S_UP_WR;
        end
      end
      S_UP_WR: begin
        ctl.wr_en  = 1'b1;
        ctl.wr_sel = WR_RDATA;
        ctl.idx_op = IDX_DEC;
        state_next = S_UP_CHK;
      end
      S_DN_CHK: begin
        if (flags.idx_p1_lt_cnt) begin
          ctl.rd_en  = 1'b1;
          ctl.rd_sel = RD_IDX_P1;
          state_next = S_DN_WR;
        end else begin
          ctl.cnt_op      = CNT_DEC;
          ctl.res_load    = 1'b1;
          ctl.res_status  = ST_OK;
          ctl.res_idx_sel = RES_IDX_POS;
          state_next      = S_FIN;
        end
      end
      S_DN_WR: begin
        ctl.wr_en  = 1'b1;
        ctl.wr_sel = WR_RDATA;
        ctl.idx_op = IDX_INC;
        state_next = S_DN_CHK;
      end
      S_SCAN_CHK: begin
        if (flags.idx_lt_cnt) begin
          ctl.rd_en  = 1'b1;
          ctl.rd_sel = RD_IDX;
          state_next = S_SCAN_CMP;
        end else if (flags.cmd == CMD_LOCATE) begin
          ctl.res_load   = 1'b1;
          ctl.res_status = ST_NOTFOUND;
          state_next     = S_FIN;
        end else begin
          // sorted insert lands at the end of the list
          ctl.pos_from_idx = 1'b1;
          ctl.idx_op       = IDX_COUNT;
          state_next       = S_UP_CHK;
        end
      end
      S_SCAN_CMP: begin
        if (flags.cmd == CMD_LOCATE) begin
          if (flags.match) begin
            ctl.res_load    = 1'b1;
            ctl.res_status  = ST_OK;
            ctl.res_idx_sel = RES_IDX_IDX;
            state_next      = S_FIN;
          end else begin
            ctl.idx_op = IDX_INC;
            state_next = S_SCAN_CHK;
          end
        end else if (flags.less) begin
          ctl.idx_op = IDX_INC;
          state_next = S_SCAN_CHK;
        end else begin
          ctl.pos_from_idx = 1'b1;
          ctl.idx_op       = IDX_COUNT;
          state_next       = S_UP_CHK;
        end
      end
      S_RD_WAIT: begin
        ctl.res_load    = 1'b1;
        ctl.res_status  = ST_OK;
        ctl.res_idx_sel = RES_IDX_POS;
        ctl.res_rd_sel  = RES_RD_DATA;
        state_next      = S_FIN;
      end
      S_FIN: begin
        if (flags.out_free) begin
          ctl.out_load = 1'b1;
          state_next   = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

endmodule

// ===== design/bounded_array_list_unit.sv =====
// bounded array list: ordered list of up to DEPTH signed 32-bit entries and a count
// req channel (valid/ready) carries one command transaction: command, value, position
//   insert at position, delete at position, locate value, sorted insert, read
// rsp channel (valid/ready) returns exactly one transaction per command with
//   status, found_index, read_value and the entry count after the command
// one command is in flight at a time; req.ready is high only while the unit is idle
// time from acceptance to rsp.valid is set by the list memory (one read, one write a cycle):
//   read does one memory read, a rejected or unused command is answered from decode
//   insert moves each entry from position to count - 1 up one slot, delete each entry above
//   position down one slot, each move a memory read and then a write
//   locate reads and compares entries in order until one matches; sorted insert adds its scan
//   to the insert shift; after the result is loaded the unit returns to idle for the next command
// the finished result sits in an output register, so a stalled rsp holds only
//   the following command's result; that command waits in its final state
// reset (rst, synchronous, active high) empties the list and drops any pending
//   response; slots above the count are never read, so no memory clearing is needed
module bounded_array_list_unit #(
  parameter int DEPTH = bal_pkg::DEPTH_DEFAULT
) (
  input logic       clk,
  input logic       rst,
  bal_req_if.sink   req,
  bal_rsp_if.source rsp
);
  import bal_pkg::*;

  bal_ctl_t   ctl;
  bal_flags_t flags;

  // sequencing: decode, shift loops, scans, response hand-off
  bal_controller u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (req.valid),
    .in_ready (req.ready),
    .flags    (flags),
    .ctl      (ctl)
  );

  // list memory, count, index counter, compares and output register
  bal_datapath #(
    .DEPTH (DEPTH)
  ) u_dp (
    .clk         (clk),
    .rst         (rst),
    .ctl         (ctl),
    .command     (req.command),
    .value       (req.value),
    .position    (req.position),
    .flags       (flags),
    .out_valid   (rsp.valid),
    .out_ready   (rsp.ready),
    .status      (rsp.status),
    .found_index (rsp.found_index),
    .read_value  (rsp.read_value),
    .entry_count (rsp.entry_count)
  );

endmodule

// ===== dv/bounded_array_list_unit_tb.sv =====
module bounded_array_list_unit_tb;
  import bal_pkg::*;

  localparam int CLK_PERIOD   = 4;
  localparam int RESET_CYCLES = 10;
  localparam int LIST_DEPTH   = DEPTH_DEFAULT;
  localparam int MAX_IDLE     = 18;
  localparam int RANDOM_ITEMS = 1130;
  // longest command is a sorted insert into a nearly full list,
  // plus a full request gap and a full response stall; keep a wide margin
  localparam int STALL_LIMIT  = 2000;
  localparam int DRAIN_CYCLES = 100;
  localparam int MAX_REPORTS  = 10;

  // command codes the block has no name for, all of them ignored
  localparam logic [CMD_W-1:0] CMD_UNUSED_LO  = 3'd5;
  localparam logic [CMD_W-1:0] CMD_UNUSED_MID = 3'd6;
  localparam logic [CMD_W-1:0] CMD_UNUSED_HI  = 3'd7;

  // refill value of freed slots and the signed extremes
  localparam logic signed [VAL_W-1:0] FILL_VALUE = -32'sd1;
  localparam logic signed [VAL_W-1:0] VAL_MAX    = 32'sh7FFF_FFFF;
  localparam logic signed [VAL_W-1:0] VAL_MIN    = 32'sh8000_0000;

  typedef enum int {PH_GROW, PH_SHRINK, PH_MIX} phase_t;

  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic [IDX_W-1:0]    found_index;
    logic [VAL_W-1:0]    read_value;
    logic [CNT_W-1:0]    entry_count;
  } list_result_t;

  // shadow copy of the list; predicts each response and checks it in order
  class list_checker;
    logic signed [VAL_W-1:0] entries[LIST_DEPTH];
    int count;
    int peak_count;
    int commands_seen;
    int mismatches;
    int status_seen[4];
    list_result_t pending_results[$];

    function new();
      foreach (entries[i]) entries[i] = FILL_VALUE;
      count = 0;
      peak_count = 0;
      commands_seen = 0;
      mismatches = 0;
      foreach (status_seen[i]) status_seen[i] = 0;
    endfunction

    // open a gap at slot, moving later entries up by one
    function void insert_at(int slot, logic signed [VAL_W-1:0] val);
      int i;
      for (i = count; i > slot; i--) entries[i] = entries[i-1];
      entries[slot] = val;
      count++;
      if (count > peak_count) peak_count = count;
    endfunction

    function list_result_t apply_command(logic [CMD_W-1:0] cmd, logic signed [VAL_W-1:0] val,
                                         logic [POS_W-1:0] pos);
      list_result_t res;
      int slot;
      res = '0;
      res.status = ST_OK;
      case (cmd)
        CMD_INSERT: begin
          if (count >= LIST_DEPTH) res.status = ST_FULL;
          else if (int'(pos) > count) res.status = ST_BADPOS;
          else begin
            insert_at(int'(pos), val);
            res.found_index = pos[IDX_W-1:0];
          end
        end
        CMD_DELETE: begin
          if (int'(pos) >= count) res.status = ST_BADPOS;
          else begin
            for (slot = int'(pos); slot + 1 < count; slot++) entries[slot] = entries[slot+1];
            entries[count-1] = FILL_VALUE;
            count--;
            res.found_index = pos[IDX_W-1:0];
          end
        end
        CMD_LOCATE: begin
          // first match wins
          res.status = ST_NOTFOUND;
          for (slot = 0; slot < count; slot++) begin
            if (res.status == ST_NOTFOUND && entries[slot] == val) begin
              res.status = ST_OK;
              res.found_index = slot[IDX_W-1:0];
            end
          end
        end
        CMD_SORTED: begin
          if (count >= LIST_DEPTH) res.status = ST_FULL;
          else begin
            // signed compare: stop at the first entry not less than the value
            slot = 0;
            while (slot < count && entries[slot] < val) slot++;
            insert_at(slot, val);
            res.found_index = slot[IDX_W-1:0];
          end
        end
        CMD_READ: begin
          if (int'(pos) >= count) res.status = ST_BADPOS;
          else begin
            res.read_value = entries[pos];
            res.found_index = pos[IDX_W-1:0];
          end
        end
        default: ;  // unused codes leave everything alone
      endcase
      res.entry_count = count[CNT_W-1:0];
      return res;
    endfunction

    function void note_command(logic [CMD_W-1:0] cmd, logic signed [VAL_W-1:0] val,
                               logic [POS_W-1:0] pos);
      commands_seen++;
      pending_results.push_back(apply_command(cmd, val, pos));
    endfunction

    function void check_result(list_result_t got);
      list_result_t want;
      if (pending_results.size() == 0) begin
        mismatches++;
        if (mismatches <= MAX_REPORTS)
          $display("unexpected response: status %0d index %0d read %0d count %0d",
                   got.status, got.found_index, $signed(got.read_value), got.entry_count);
        return;
      end
      want = pending_results.pop_front();
      status_seen[want.status]++;
      if (got.status !== want.status || got.found_index !== want.found_index ||
          got.read_value !== want.read_value || got.entry_count !== want.entry_count) begin
        mismatches++;
        if (mismatches <= MAX_REPORTS) begin
          $display("response mismatch: expected status %0d index %0d read %0d count %0d",
                   want.status, want.found_index, $signed(want.read_value), want.entry_count);
          $display("                   actual   status %0d index %0d read %0d count %0d",
                   got.status, got.found_index, $signed(got.read_value), got.entry_count);
        end
      end
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst;
  logic steady;  // when set, neither side idles
  int   quiet_cycles;
  list_checker chk;

  bal_req_if req_ch();
  bal_rsp_if rsp_ch();

  bounded_array_list_unit #(.DEPTH(LIST_DEPTH)) DUT (
    .clk(clk),
    .rst(rst),
    .req(req_ch),
    .rsp(rsp_ch)
  );

  always #(CLK_PERIOD/2) clk = ~clk;

  // one command transaction; valid stays high across back-to-back transactions
  task automatic send_cmd(input logic [CMD_W-1:0] cmd, input logic signed [VAL_W-1:0] val,
                          input logic [POS_W-1:0] pos);
    int gap;
    gap = steady ? 0 : $urandom_range(0, MAX_IDLE);
    if (gap > 0) begin
      req_ch.valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    req_ch.valid    <= 1'b1;
    req_ch.command  <= cmd;
    req_ch.value    <= val;
    req_ch.position <= pos;
    @(posedge clk);
    while (!req_ch.ready) @(posedge clk);
    @(negedge clk);
  endtask

  // extremes, small values that collide, live entries, and full random words
  function automatic logic signed [VAL_W-1:0] pick_value();
    int r;
    r = $urandom_range(0, 9);
    if (r == 0) begin
      case ($urandom_range(0, 3))
        0: return VAL_MAX;
        1: return VAL_MIN;
        2: return FILL_VALUE;
        default: return '0;
      endcase
    end
    if (r <= 3) return $signed($urandom_range(0, 16)) - 8;
    if (r <= 5 && chk.count > 0) return chk.entries[$urandom_range(0, chk.count - 1)];
    return $urandom;
  endfunction

  // mostly legal positions for the current length, now and then anything in range
  function automatic logic [POS_W-1:0] pick_position(logic [CMD_W-1:0] cmd);
    if ($urandom_range(0, 9) == 0) return POS_W'($urandom_range(0, (1 << POS_W) - 1));
    if (cmd == CMD_INSERT) return POS_W'($urandom_range(0, chk.count));
    if (chk.count == 0) return '0;
    return POS_W'($urandom_range(0, chk.count - 1));
  endfunction

  // mix of commands per phase so the list fills up, drains and hovers
  function automatic logic [CMD_W-1:0] pick_command(phase_t phase);
    int r;
    r = $urandom_range(0, 99);
    case (phase)
      PH_GROW: begin
        if (r < 45) return CMD_INSERT;
        if (r < 80) return CMD_SORTED;
        if (r < 85) return CMD_DELETE;
        if (r < 92) return CMD_LOCATE;
        if (r < 98) return CMD_READ;
      end
      PH_SHRINK: begin
        if (r < 10) return CMD_INSERT;
        if (r < 20) return CMD_SORTED;
        if (r < 65) return CMD_DELETE;
        if (r < 78) return CMD_LOCATE;
        if (r < 96) return CMD_READ;
      end
      default: begin
        if (r < 20) return CMD_INSERT;
        if (r < 40) return CMD_SORTED;
        if (r < 60) return CMD_DELETE;
        if (r < 78) return CMD_LOCATE;
        if (r < 97) return CMD_READ;
      end
    endcase
    return CMD_W'($urandom_range(CMD_UNUSED_LO, CMD_UNUSED_HI));
  endfunction

  task automatic run_directed();
    // empty list: every position is bad, nothing to find
    send_cmd(CMD_READ, '0, 5'd0);
    send_cmd(CMD_DELETE, '0, 5'd0);
    send_cmd(CMD_LOCATE, '0, 5'd0);
    send_cmd(CMD_INSERT, 32'sd7, 5'd1);
    // extremes, then sorted inserts around them
    send_cmd(CMD_INSERT, VAL_MAX, 5'd0);
    send_cmd(CMD_INSERT, VAL_MIN, 5'd1);
    send_cmd(CMD_SORTED, '0, 5'd0);
    send_cmd(CMD_SORTED, FILL_VALUE, 5'd0);
    send_cmd(CMD_SORTED, '0, 5'd0);
    // duplicates: locate must report the first one
    send_cmd(CMD_LOCATE, '0, 5'd0);
    send_cmd(CMD_LOCATE, 32'sd12345, 5'd0);
    send_cmd(CMD_LOCATE, VAL_MIN, 5'd0);
    send_cmd(CMD_READ, '0, 5'd0);
    send_cmd(CMD_READ, '0, 5'd4);
    send_cmd(CMD_READ, '0, 5'd5);
    send_cmd(CMD_READ, '0, 5'd31);
    send_cmd(CMD_INSERT, 32'sh5555_5555, 5'd31);
    send_cmd(CMD_INSERT, 32'sh5555_5555, 5'd0);
    send_cmd(CMD_SORTED, 32'shAAAA_AAAA, 5'd16);
    // middle, top and out-of-range deletes
    send_cmd(CMD_DELETE, '0, 5'd2);
    send_cmd(CMD_DELETE, '0, 5'd5);
    send_cmd(CMD_DELETE, '0, 5'd16);
    // codes with no operation
    send_cmd(CMD_UNUSED_LO, VAL_MAX, 5'd3);
    send_cmd(CMD_UNUSED_MID, VAL_MIN, 5'd16);
    send_cmd(CMD_UNUSED_HI, FILL_VALUE, 5'd31);
  endtask

  task automatic run_random();
    phase_t phase;
    int left_in_phase;
    int n;
    logic [CMD_W-1:0] cmd;
    phase = PH_GROW;
    left_in_phase = 0;
    for (n = 0; n < RANDOM_ITEMS; n++) begin
      if (left_in_phase == 0) begin
        phase = phase_t'($urandom_range(0, 2));
        steady = ($urandom_range(0, 4) == 0);
        left_in_phase = $urandom_range(20, 60);
      end
      left_in_phase--;
      cmd = pick_command(phase);
      send_cmd(cmd, pick_value(), pick_position(cmd));
    end
    steady = 1'b0;
  endtask

  // response side: random stall before each response, none during steady stretches
  initial begin
    int stall;
    rsp_ch.ready = 1'b0;
    @(negedge clk);
    while (rst) @(negedge clk);
    forever begin
      stall = steady ? 0 : $urandom_range(0, MAX_IDLE);
      if (stall > 0) begin
        rsp_ch.ready <= 1'b0;
        repeat (stall) @(negedge clk);
      end
      rsp_ch.ready <= 1'b1;
      @(posedge clk);
      while (!rsp_ch.valid) @(posedge clk);
      @(negedge clk);
    end
  end

  // transaction monitor on both channels
  always @(posedge clk) begin
    if (!rst) begin
      if (rsp_ch.valid && rsp_ch.ready)
        chk.check_result('{rsp_ch.status, rsp_ch.found_index, rsp_ch.read_value,
                           rsp_ch.entry_count});
      if (req_ch.valid && req_ch.ready)
        chk.note_command(req_ch.command, req_ch.value, req_ch.position);
    end
  end

  // watchdog: too long without any transaction means the block hung
  always @(posedge clk) begin
    if (rst || (req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= STALL_LIMIT) begin
      $display("timeout: no transaction for %0d cycles", STALL_LIMIT);
      $display("[bounded_array_list_unit] ERROR");
      $finish;
    end
  end

  initial begin
    chk = new();
    rst = 1'b1;
    steady = 1'b0;
    req_ch.valid = 1'b0;
    req_ch.command = '0;
    req_ch.value = '0;
    req_ch.position = '0;
    repeat (RESET_CYCLES) @(negedge clk);
    rst <= 1'b0;

    run_directed();
    run_random();
    req_ch.valid <= 1'b0;

    // let outstanding responses come back, then watch for stray ones
    while (chk.pending_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("ran %0d commands; list length peaked at %0d of %0d", chk.commands_seen,
             chk.peak_count, LIST_DEPTH);
    $display("statuses: ok %0d, full %0d, bad position %0d, not found %0d; mismatches %0d",
             chk.status_seen[ST_OK], chk.status_seen[ST_FULL], chk.status_seen[ST_BADPOS],
             chk.status_seen[ST_NOTFOUND], chk.mismatches);
    if (chk.mismatches == 0 && chk.pending_results.size() == 0)
      $display("[bounded_array_list_unit] OK");
    else
      $display("[bounded_array_list_unit] ERROR");
    $finish;
  end

endmodule
